FILE: sv/rras_pkg.sv
// Shared types and constants for the round robin aging scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rras_pkg;

  // Default number of task slots.
  localparam int SLOTS_DEFAULT = 16;

  // Field widths fixed by the interface.
  localparam int TIME_W  = 16;
  localparam int LEVEL_W = 4;
  localparam int SLOT_W  = 4;
  localparam int EVENT_W = 3;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 2;

  // Register reset values.
  localparam logic [TIME_W-1:0]  QUANTUM_RESET      = 16'd30;
  localparam logic [LEVEL_W-1:0] TOP_PRIORITY_RESET = 4'd10;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX          = 4'hF;

  // Register indexes on the configuration port.
  localparam logic [INDEX_W-1:0] CFG_QUANTUM      = 2'd0;
  localparam logic [INDEX_W-1:0] CFG_AGING_MODE   = 2'd1;
  localparam logic [INDEX_W-1:0] CFG_TOP_PRIORITY = 2'd2;

  // Input actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Result event codes.
  localparam logic [EVENT_W-1:0] EV_REQUEUE = 3'd0;
  localparam logic [EVENT_W-1:0] EV_FINISH  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_AGED    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_IDLE    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LOAD    = 3'd4;

  // Configuration register set as seen by the core.
  typedef struct packed {
    logic [TIME_W-1:0]  quantum;
    logic               aging_mode;
    logic [LEVEL_W-1:0] top_priority;
  } cfg_t;

  // One slot entry held in the slot memory.
  typedef struct packed {
    logic [TIME_W-1:0]  remaining;
    logic [LEVEL_W-1:0] base;
    logic [LEVEL_W-1:0] aged;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/rras_mem.sv
// Slot memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rras_mem #(
  parameter int SLOTS = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire rras_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output rras_pkg::entry_t     rdata
);
  import rras_pkg::*;

  entry_t mem [SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/rras_core.sv
// Scheduler core: slot scan, read-modify-write of the slot memory and result register.
`timescale 1ns / 1ps
`default_nettype none

module rras_core #(
  parameter int SLOTS = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          action,
  input  wire logic [rras_pkg::SLOT_W-1:0]   slot,
  input  wire logic [rras_pkg::LEVEL_W-1:0]  base_priority,
  input  wire logic [rras_pkg::TIME_W-1:0]   burst_time,
  input  wire rras_pkg::cfg_t                cfg,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output rras_pkg::entry_t                   mem_wdata,
  output logic                               mem_re,
  output logic [AW-1:0]                      mem_raddr,
  input  wire rras_pkg::entry_t              mem_rdata,
  output logic                               done,
  output logic [rras_pkg::SLOT_W-1:0]        served_slot,
  output logic [rras_pkg::EVENT_W-1:0]       event_res,
  output logic [rras_pkg::TIME_W-1:0]        time_left,
  output logic [rras_pkg::LEVEL_W-1:0]       aged_level,
  output logic [rras_pkg::COUNT_W-1:0]       active_left
);
  import rras_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  state_t          state;
  logic [SLOTS-1:0] active;
  logic [CW-1:0]   count;
  logic [AW-1:0]   pointer;
  logic [AW-1:0]   scan_idx;
  logic [AW-1:0]   cur_slot;

  logic               accept;
  logic               load_in_range;
  logic [AW-1:0]      load_addr;
  logic [LEVEL_W-1:0] load_base;
  logic               load_now;
  logic [CW-1:0]      load_count;
  logic               scan_hit;
  logic [AW-1:0]      scan_next;
  logic [AW-1:0]      ptr_next;

  logic               aging_hold;
  logic [LEVEL_W-1:0] aged_inc;
  logic               run_gt;
  logic [TIME_W-1:0]  exec_rem;
  logic [LEVEL_W-1:0] exec_aged;
  logic               exec_finish;
  logic [EVENT_W-1:0] exec_ev;
  logic [CW-1:0]      exec_count;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Load word: range check, priority clamp and active count update.
  assign load_in_range = (32'(slot) < SLOTS);
  assign load_addr     = AW'(slot);
  assign load_base     = (base_priority > cfg.top_priority) ? cfg.top_priority : base_priority;
  assign load_now      = (burst_time != '0);
  assign load_count    = count - CW'(active[load_addr]) + CW'(load_now);

  // Scan walks the active bits one slot per cycle, wrapping at the last slot.
  assign scan_hit  = active[scan_idx];
  assign scan_next = (scan_idx == LAST_SLOT) ? '0 : scan_idx + 1'b1;
  assign ptr_next  = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;

  // Step arithmetic on the entry read back from memory.
  assign aging_hold  = cfg.aging_mode && (mem_rdata.aged < cfg.top_priority);
  assign aged_inc    = (mem_rdata.aged == LEVEL_MAX) ? mem_rdata.aged : mem_rdata.aged + 1'b1;
  assign run_gt      = (mem_rdata.remaining > cfg.quantum);
  assign exec_finish = !aging_hold && !run_gt;

  always_comb begin
    if (aging_hold) begin
      exec_rem  = mem_rdata.remaining;
      exec_aged = aged_inc;
      exec_ev   = EV_AGED;
    end else begin
      exec_rem  = run_gt ? (mem_rdata.remaining - cfg.quantum) : '0;
      exec_aged = cfg.aging_mode ? mem_rdata.base : mem_rdata.aged;
      exec_ev   = run_gt ? EV_REQUEUE : EV_FINISH;
    end
  end

  assign exec_count = exec_finish ? count - 1'b1 : count;

  // Memory requests: loads write on accept, steps read in the scan hit and write back after.
  always_comb begin
    mem_re    = (state == ST_SCAN) && scan_hit;
    mem_raddr = scan_idx;
    if (state == ST_EXEC) begin
      mem_we    = 1'b1;
      mem_waddr = cur_slot;
      mem_wdata = '{remaining: exec_rem, base: mem_rdata.base, aged: exec_aged};
    end else begin
      mem_we    = accept && (action == ACT_LOAD) && load_in_range;
      mem_waddr = load_addr;
      mem_wdata = '{remaining: burst_time, base: load_base, aged: load_base};
    end
  end

  // Control state: sequencer, active bits, count and pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      active  <= '0;
      count   <= '0;
      pointer <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == ACT_LOAD) begin
              done <= 1'b1;
              if (load_in_range) begin
                active[load_addr] <= load_now;
                count             <= load_count;
              end
            end else if (active == '0) begin
              done <= 1'b1;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done             <= 1'b1;
          pointer          <= ptr_next;
          active[cur_slot] <= !exec_finish;
          count            <= exec_count;
          state            <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Scan index, served slot and result word.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        scan_idx <= pointer;
        if (accept) begin
          if (action == ACT_LOAD) begin
            served_slot <= slot;
            event_res   <= EV_LOAD;
            time_left   <= load_in_range ? burst_time : '0;
            aged_level  <= load_in_range ? load_base : '0;
            active_left <= load_in_range ? COUNT_W'(load_count) : COUNT_W'(count);
          end else begin
            served_slot <= '0;
            event_res   <= EV_IDLE;
            time_left   <= '0;
            aged_level  <= '0;
            active_left <= '0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          cur_slot <= scan_idx;
        end else begin
          scan_idx <= scan_next;
        end
      end
      ST_EXEC: begin
        served_slot <= SLOT_W'(cur_slot);
        event_res   <= exec_ev;
        time_left   <= exec_rem;
        aged_level  <= exec_aged;
        active_left <= COUNT_W'(exec_count);
      end
      default: begin
        scan_idx <= pointer;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/round_robin_aging_scheduler.sv
// Top level: configuration registers, scheduler core and slot memory.
// A load word gives its result in the cycle after start; a step with no active slot too.
// A step scans from the pointer, checking one active bit per cycle and wrapping at the
// last slot; on a hit the slot memory is read, then the entry is written back
// and the result registered. One word is in flight at a time.
// Synchronous reset clears active bits, count, pointer, done; config gets reset values.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_aging_scheduler #(
  parameter int SLOTS = rras_pkg::SLOTS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          action,
  input  wire logic [rras_pkg::SLOT_W-1:0]   slot,
  input  wire logic [rras_pkg::LEVEL_W-1:0]  base_priority,
  input  wire logic [rras_pkg::TIME_W-1:0]   burst_time,
  output logic                               done,
  output logic [rras_pkg::SLOT_W-1:0]        served_slot,
  output logic [rras_pkg::EVENT_W-1:0]       event_res,
  output logic [rras_pkg::TIME_W-1:0]        time_left,
  output logic [rras_pkg::LEVEL_W-1:0]       aged_level,
  output logic [rras_pkg::COUNT_W-1:0]       active_left,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rras_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [rras_pkg::TIME_W-1:0]   cfg_data
);
  import rras_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  cfg_t          cfg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // Configuration registers; a word to an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quantum      <= QUANTUM_RESET;
      cfg.aging_mode   <= 1'b0;
      cfg.top_priority <= TOP_PRIORITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUANTUM:      cfg.quantum      <= cfg_data;
        CFG_AGING_MODE:   cfg.aging_mode   <= cfg_data[0];
        CFG_TOP_PRIORITY: cfg.top_priority <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rras_core #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .CW    (CW)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .slot          (slot),
    .base_priority (base_priority),
    .burst_time    (burst_time),
    .cfg           (cfg),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .done          (done),
    .served_slot   (served_slot),
    .event_res     (event_res),
    .time_left     (time_left),
    .aged_level    (aged_level),
    .active_left   (active_left)
  );

  rras_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: sv/rras_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rras_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          action,
  input wire logic                          done,
  input wire logic [rras_pkg::SLOT_W-1:0]   served_slot,
  input wire logic [rras_pkg::EVENT_W-1:0]  event_res,
  input wire logic [rras_pkg::TIME_W-1:0]   time_left,
  input wire logic [rras_pkg::LEVEL_W-1:0]  aged_level,
  input wire logic [rras_pkg::COUNT_W-1:0]  active_left
);
  import rras_pkg::*;

  // A load word always reports in the next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_LOAD) |=> (done && event_res == EV_LOAD))
    else $error("load word did not report in the next cycle");

  // A step word either reports idle at once or starts scanning.
  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_STEP) |=> (busy || (done && event_res == EV_IDLE)))
    else $error("step word neither went busy nor reported idle");

  // An idle result carries all-zero fields.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (done && event_res == EV_IDLE) |->
      (served_slot == '0 && time_left == '0 && aged_level == '0 && active_left == '0))
    else $error("idle result carries nonzero fields");

  // No result is strobed while a step is still in progress.
  a_busy_quiet: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobed while busy");

endmodule

bind round_robin_aging_scheduler rras_checker u_rras_checker (.*);

`default_nettype wire
